// ===== src/wgm_pkg.sv =====
// shared types, codes and helpers for the wildcard glob matcher
`default_nettype none

package wgm_pkg;

    // pattern codes with a wildcard meaning
    localparam logic [15:0] GLOB_ANY_ONE = 16'h003F;
    localparam logic [15:0] GLOB_ANY_RUN = 16'h002A;

    // ascii range folded to lower case
    localparam logic [15:0] ASCII_UPPER_A = 16'h0041;
    localparam logic [15:0] ASCII_UPPER_Z = 16'h005A;
    localparam logic [15:0] ASCII_CASE_OFFSET = 16'h0020;

    // configuration register indexes
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PATTERN_CHARS_0_3   = 3'd0;
    localparam t_cfg_idx CFG_PATTERN_CHARS_4_7   = 3'd1;
    localparam t_cfg_idx CFG_PATTERN_CHARS_8_11  = 3'd2;
    localparam t_cfg_idx CFG_PATTERN_CHARS_12_15 = 3'd3;
    localparam t_cfg_idx CFG_PATTERN_LENGTH      = 3'd4;

    // register geometry
    localparam int CFG_DATA_W     = 64;
    localparam int CHAR_W         = 16;
    localparam int CHARS_PER_WORD = 4;
    localparam int CFG_CHAR_SLOTS = 16;
    localparam int CFG_LENGTH_W   = 5;

    // one name item as held in the input register
    typedef struct packed {
        logic [15:0] name_char;
        logic        last_char;
        logic        name_empty;
    } t_item;

    // fold ascii upper case to lower case, everything else unchanged
    function automatic logic [15:0] fold_ascii(input logic [15:0] c);
        logic [15:0] r;
        r = c;
        if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
            r = c + ASCII_CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/wildcard_glob_matcher.sv =====
// top level of the streaming case-insensitive glob matcher
`default_nettype none

// Matches streamed names against a glob pattern held in configuration: '?'
// takes any one character, '*' any run (also empty), other characters compare
// after folding ASCII A-Z to lower case. Send one name character per item with
// tlast on the final one; an item with tuser[0] set stands for an empty name
// and carries no character. Each name gives one result item (tdata[0] = match)
// at its end. Throughput is one character per clock unless a name-end item
// waits on a held result: the set of active pattern positions is updated in
// a single pass between the input register and the state register, so a new
// item is taken every cycle; the result register offers the result item once
// its name-end item leaves the input register. Write the pattern only while
// no name is being fed or between names. The output register holds a result
// while the sink stalls and the input side keeps taking mid-name characters.
module wildcard_glob_matcher #(
    parameter int MAX_PATTERN_LENGTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    // name input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] name_char
    input  logic        s_axis_tlast,
    input  logic [0:0]  s_axis_tuser,   // [0] name_empty
    // match output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] matched, [7:1] zero
);

    localparam int N  = MAX_PATTERN_LENGTH;
    localparam int LW = $clog2(N + 1);
    localparam int NS = (N < wgm_pkg::CFG_CHAR_SLOTS) ? N : wgm_pkg::CFG_CHAR_SLOTS;
    localparam logic [N:0] ACTIVE_RESET = {{N{1'b0}}, 1'b1};

    logic [NS-1:0][15:0]                  r_pattern;
    logic [wgm_pkg::CFG_LENGTH_W-1:0]     r_len;
    logic [N-1:0][15:0]                   pattern_full;
    logic [LW-1:0]                        used_len;

    logic                                 r_in_valid;
    wgm_pkg::t_item                       r_item;
    logic [N:0]                           r_active;
    logic [N:0]                           n_active;
    logic                                 step_matched;

    logic                                 r_out_valid;
    logic                                 r_matched;

    logic                                 gives_result;
    logic                                 proc;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_len     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wgm_pkg::CFG_PATTERN_CHARS_0_3,
                wgm_pkg::CFG_PATTERN_CHARS_4_7,
                wgm_pkg::CFG_PATTERN_CHARS_8_11,
                wgm_pkg::CFG_PATTERN_CHARS_12_15: begin
                    for (int s = 0; s < NS; s++) begin
                        if (i_cfg_idx[1:0] == 2'(s / wgm_pkg::CHARS_PER_WORD)) begin
                            r_pattern[s] <= i_cfg_data[(s % wgm_pkg::CHARS_PER_WORD)
                                                       * wgm_pkg::CHAR_W +: wgm_pkg::CHAR_W];
                        end
                    end
                end
                wgm_pkg::CFG_PATTERN_LENGTH: begin
                    r_len <= i_cfg_data[wgm_pkg::CFG_LENGTH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // pattern positions past the register slots read as zero characters
    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_pat
            if (g < NS) begin : g_stored
                assign pattern_full[g] = r_pattern[g];
            end else begin : g_zero
                assign pattern_full[g] = '0;
            end
        end
    endgenerate

    // length saturates at the pattern capacity
    always_comb begin
        if (int'(r_len) > N) begin
            used_len = LW'(N);
        end else begin
            used_len = LW'(r_len);
        end
    end

    // handshake: an item leaves the input register unless its result is blocked
    assign gives_result  = r_item.last_char || r_item.name_empty;
    assign proc          = r_in_valid && (!gives_result || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || proc;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item.name_char  <= s_axis_tdata;
            r_item.last_char  <= s_axis_tlast;
            r_item.name_empty <= s_axis_tuser[0];
        end
    end

    // one-pass position update
    wgm_step #(
        .N (N)
    ) u_step (
        .i_item        (r_item),
        .i_active      (r_active),
        .i_pattern     (pattern_full),
        .i_len         (used_len),
        .o_active_next (n_active),
        .o_matched     (step_matched)
    );

    // active-position state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (proc) begin
            r_active <= n_active;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && gives_result) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && gives_result) begin
            r_matched <= step_matched;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_matched};

`ifndef NO_ASSERTIONS
    // a name end always leaves the position set at its restart value
    a_restart_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && gives_result) |=> (r_active == ACTIVE_RESET))
        else $error("active positions not restarted after name end");

    // a new result appears only when a name-end item was processed
    a_result_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid ##1 r_out_valid) |-> $past(proc && gives_result))
        else $error("result shown without a name-end item");

    // a held item in the input register does not change while it waits
    a_input_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !proc) |=> (r_in_valid && $stable(r_item)))
        else $error("stalled input item lost or changed");

    // the state never moves without an item being processed
    a_state_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!proc && $past(i_rst_n)) |=> $stable(r_active))
        else $error("active positions changed with no item");
`endif

endmodule

`default_nettype wire

// ===== src/wgm_step.sv =====
// next active-position set and match bit for one name item
`default_nettype none

module wgm_step #(
    parameter int N = 16
) (
    input  wgm_pkg::t_item                 i_item,
    input  logic [N:0]                     i_active,
    input  logic [N-1:0][15:0]             i_pattern,
    input  logic [$clog2(N+1)-1:0]         i_len,
    output logic [N:0]                     o_active_next,
    output logic                           o_matched
);

    localparam int LW = $clog2(N + 1);
    localparam logic [N:0] ACTIVE_RESET = {{N{1'b0}}, 1'b1};

    logic [N-1:0] in_use;
    logic [N-1:0] is_run;
    logic [N-1:0] is_step;
    logic [N-1:0] run_mask;
    logic [15:0]  name_fold;
    logic [N:0]   cur;
    logic [N:0]   nxt;
    logic [N:0]   fin;
    logic [N:0]   empty_set;

    // a reached star also reaches the position after it; the spread through
    // a run of stars is the carry chain of (start bits + star mask)
    function automatic logic [N:0] expand(input logic [N:0] src, input logic [N-1:0] run);
        logic [N:0] s;
        logic [N:0] a;
        logic [N:0] c;
        s = {1'b0, run};
        a = src & s;
        c = (a + s) ^ a ^ s;
        return src | c;
    endfunction

    // per-position character classes
    assign name_fold = wgm_pkg::fold_ascii(i_item.name_char);
    always_comb begin
        for (int i = 0; i < N; i++) begin
            in_use[i]  = (LW'(i) < i_len);
            is_run[i]  = (i_pattern[i] == wgm_pkg::GLOB_ANY_RUN);
            is_step[i] = (i_pattern[i] == wgm_pkg::GLOB_ANY_ONE)
                      || (wgm_pkg::fold_ascii(i_pattern[i]) == name_fold);
        end
    end
    assign run_mask = is_run & in_use;

    // advance the active set by one character
    assign cur = expand(i_active, run_mask);
    always_comb begin
        nxt = '0;
        for (int i = 0; i < N; i++) begin
            if (cur[i] && in_use[i]) begin
                if (is_run[i]) begin
                    nxt[i] = 1'b1;
                end else if (is_step[i]) begin
                    nxt[i+1] = 1'b1;
                end
            end
        end
    end

    // end-of-name evaluation
    assign fin       = expand(nxt, run_mask);
    assign empty_set = expand(ACTIVE_RESET, run_mask);

    always_comb begin
        priority if (i_item.name_empty) begin
            o_matched     = empty_set[i_len];
            o_active_next = ACTIVE_RESET;
        end else if (i_item.last_char) begin
            o_matched     = fin[i_len];
            o_active_next = ACTIVE_RESET;
        end else begin
            o_matched     = 1'b0;
            o_active_next = nxt;
        end
    end

endmodule

`default_nettype wire

// ===== test/wildcard_glob_matcher_tb.sv =====
// self-checking testbench for the streaming wildcard glob matcher
module wildcard_glob_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [15:0] t_chars[$];

    localparam int                GLOB_SLOTS     = 16;
    localparam int                LIMIT_CYCLES   = 400000;
    localparam int                DRAIN_CYCLES   = 4;
    localparam wgm_pkg::t_cfg_idx UNUSED_CFG_IDX = 3'd5;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [2:0]  i_cfg_idx     = '0;
    logic [63:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // [15:0] name_char
    logic        s_axis_tlast  = 1'b0;
    logic [0:0]  s_axis_tuser  = '0;   // [0] name_empty
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [0] matched, [7:1] zero

    // glob state mirrored on the testbench side
    logic [15:0] glob_pat [GLOB_SLOTS];
    logic [4:0]  glob_len = '0;
    logic [16:0] glob_active = 17'd1;

    logic match_expect_q[$];
    int   mismatch_count = 0;
    int   cycle_count = 0;
    int   items_sent = 0;
    bit   src_idle_on = 1'b1;
    bit   sink_idle_on = 1'b1;
    int   stall_hold_request = 0;
    int   stall_hold_left = 0;
    bit   sink_hold = 1'b0;
    int   sink_gap_left = 0;

    wildcard_glob_matcher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("wildcard_glob_matcher_tb: errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // pattern length in use, saturated at the slot count
    function automatic int glob_used();
        return (glob_len > GLOB_SLOTS) ? GLOB_SLOTS : int'(glob_len);
    endfunction

    function automatic logic [15:0] lower_ascii(input logic [15:0] c);
        if (c >= 16'h0041 && c <= 16'h005A) begin
            return c + 16'h0020;
        end
        return c;
    endfunction

    function automatic bit is_letter(input logic [15:0] c);
        return (c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A);
    endfunction

    // positions reachable once stars are allowed to match nothing
    function automatic logic [16:0] glob_close(input logic [16:0] src);
        logic [16:0] dst;
        int n;
        n = glob_used();
        dst = '0;
        for (int i = 0; i <= n; i++) dst[i] = src[i];
        for (int i = 0; i < n; i++) begin
            if (dst[i] && glob_pat[i] == wgm_pkg::GLOB_ANY_RUN) dst[i + 1] = 1'b1;
        end
        return dst;
    endfunction

    // advance the active set by one item; returns 1 when the name ends
    function automatic bit glob_step(input logic [15:0] ch, input bit last, input bit empty,
                                     output logic matched);
        logic [16:0] reach;
        logic [16:0] nxt;
        int n;
        n = glob_used();
        matched = 1'b0;
        if (empty) begin
            glob_active = 17'd1;
            reach = glob_close(glob_active);
            matched = reach[n];
            return 1'b1;
        end
        reach = glob_close(glob_active);
        nxt = '0;
        for (int i = 0; i < n; i++) begin
            if (reach[i]) begin
                if (glob_pat[i] == wgm_pkg::GLOB_ANY_RUN) begin
                    nxt[i] = 1'b1;
                end else if (glob_pat[i] == wgm_pkg::GLOB_ANY_ONE ||
                             lower_ascii(glob_pat[i]) == lower_ascii(ch)) begin
                    nxt[i + 1] = 1'b1;
                end
            end
        end
        glob_active = nxt;
        if (!last) return 1'b0;
        reach = glob_close(glob_active);
        matched = reach[n];
        glob_active = 17'd1;
        return 1'b1;
    endfunction

    // long receiver hold, counted in cycles
    always @(posedge i_clk) begin : stall_side
        if (stall_hold_request > 0) begin
            stall_hold_left = stall_hold_request;
            stall_hold_request = 0;
        end
        if (stall_hold_left > 0) begin
            stall_hold_left--;
            sink_hold <= 1'b1;
        end else begin
            sink_hold <= 1'b0;
        end
    end

    // result side: check each accepted item, then choose the next tready
    always @(posedge i_clk) begin : sink_side
        logic exp_match;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (match_expect_q.size() == 0) begin
                report_mismatch($sformatf("result item %h with no name pending", m_axis_tdata));
            end else begin
                exp_match = match_expect_q.pop_front();
                if (m_axis_tdata !== {7'b0, exp_match}) begin
                    report_mismatch($sformatf("matched: got %h expected %0b",
                                              m_axis_tdata, exp_match));
                end
            end
        end
        if (sink_hold) begin
            m_axis_tready <= 1'b0;
        end else if (sink_gap_left > 0) begin
            sink_gap_left--;
            m_axis_tready <= 1'b0;
        end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
            sink_gap_left = $urandom_range(1, 9) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // send one name item and predict its result
    task automatic send_item(input logic [15:0] ch, input bit last, input bit empty);
        logic m;
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        s_axis_tuser  <= empty;
        do @(posedge i_clk); while (!s_axis_tready);
        if (glob_step(ch, last, empty, m)) match_expect_q = {match_expect_q, m};
        items_sent++;
    endtask

    task automatic send_name(input t_chars nm);
        if (nm.size() == 0) begin
            send_item(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), 1'b1);
        end else begin
            foreach (nm[i]) send_item(nm[i], i == nm.size() - 1, 1'b0);
        end
    endtask

    // stop sending and let every pending result come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (match_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write; the caller lowers the enable after the last one
    task automatic cfg_write(input wgm_pkg::t_cfg_idx idx, input logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx <= wgm_pkg::CFG_PATTERN_CHARS_12_15) begin
            for (int k = 0; k < wgm_pkg::CHARS_PER_WORD; k++) begin
                glob_pat[int'(idx) * wgm_pkg::CHARS_PER_WORD + k] =
                    data[wgm_pkg::CHAR_W * k +: wgm_pkg::CHAR_W];
            end
        end else if (idx == wgm_pkg::CFG_PATTERN_LENGTH) begin
            glob_len = data[wgm_pkg::CFG_LENGTH_W - 1:0];
        end
    endtask

    task automatic load_pattern(input logic [15:0] pc [GLOB_SLOTS], input logic [4:0] len);
        wait_drained();
        cfg_write(wgm_pkg::CFG_PATTERN_CHARS_0_3,   {pc[3],  pc[2],  pc[1],  pc[0]});
        cfg_write(wgm_pkg::CFG_PATTERN_CHARS_4_7,   {pc[7],  pc[6],  pc[5],  pc[4]});
        cfg_write(wgm_pkg::CFG_PATTERN_CHARS_8_11,  {pc[11], pc[10], pc[9],  pc[8]});
        cfg_write(wgm_pkg::CFG_PATTERN_CHARS_12_15, {pc[15], pc[14], pc[13], pc[12]});
        cfg_write(wgm_pkg::CFG_PATTERN_LENGTH, {59'b0, len});
        i_cfg_we <= 1'b0;
    endtask

    // name characters biased toward letters, wildcards and fold boundaries
    function automatic logic [15:0] rand_char();
        case ($urandom_range(0, 7))
            0: return 16'h0061 + 16'($urandom_range(0, 25));
            1: return 16'h0041 + 16'($urandom_range(0, 25));
            2: return wgm_pkg::GLOB_ANY_RUN;
            3: return wgm_pkg::GLOB_ANY_ONE;
            4, 5: return 16'($urandom_range(0, 65535));
            6: begin
                case ($urandom_range(0, 5))
                    0: return 16'h0040;
                    1: return 16'h005B;
                    2: return 16'h0060;
                    3: return 16'h007B;
                    4: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            default: return 16'h0030 + 16'($urandom_range(0, 9));
        endcase
    endfunction

    task automatic random_pattern();
        logic [15:0] pc [GLOB_SLOTS];
        logic [4:0]  len;
        case ($urandom_range(0, 9))
            0: len = 5'($urandom_range(17, 31));
            1: len = 5'd0;
            default: len = 5'($urandom_range(1, 16));
        endcase
        for (int i = 0; i < GLOB_SLOTS; i++) begin
            case ($urandom_range(0, 7))
                0, 1: pc[i] = wgm_pkg::GLOB_ANY_RUN;
                2: pc[i] = wgm_pkg::GLOB_ANY_ONE;
                3, 4: pc[i] = 16'h0061 + 16'($urandom_range(0, 25));
                5: pc[i] = 16'h0041 + 16'($urandom_range(0, 25));
                6: pc[i] = 16'($urandom_range(0, 65535));
                default: pc[i] = rand_char();
            endcase
        end
        load_pattern(pc, len);
    endtask

    // mostly names built to fit the current pattern, some mutated or random
    function automatic t_chars gen_name();
        t_chars nm;
        logic [15:0] p;
        int n;
        int pos;
        n = glob_used();
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(0, 8)) nm = {nm, rand_char()};
            return nm;
        end
        for (int i = 0; i < n; i++) begin
            p = glob_pat[i];
            if (p == wgm_pkg::GLOB_ANY_RUN) begin
                repeat ($urandom_range(0, 3)) nm = {nm, rand_char()};
            end else if (p == wgm_pkg::GLOB_ANY_ONE) begin
                nm = {nm, rand_char()};
            end else if (is_letter(p)) begin
                nm = {nm, p ^ ($urandom_range(0, 1) ? 16'h0020 : 16'h0000)};
            end else begin
                nm = {nm, p};
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
                0: if (nm.size() > 0) begin
                    pos = $urandom_range(0, nm.size() - 1);
                    nm[pos] = rand_char();
                end
                1: if (nm.size() > 0) begin
                    pos = $urandom_range(0, nm.size() - 1);
                    nm.delete(pos);
                end
                default: begin
                    pos = $urandom_range(0, nm.size());
                    nm.insert(pos, rand_char());
                end
            endcase
        end
        return nm;
    endfunction

    // register extremes: all-ones pattern, saturated length, unused index
    task automatic test_pattern_registers();
        logic [15:0] pc [GLOB_SLOTS];
        pc = '{default: 16'hFFFF};
        load_pattern(pc, 5'd31);
        @(posedge i_clk);
        cfg_write(UNUSED_CFG_IDX, '0);
        i_cfg_we <= 1'b0;
        for (int i = 0; i < GLOB_SLOTS; i++) send_item(16'hFFFF, i == GLOB_SLOTS - 1, 1'b0);
        pc = '{default: 16'h0000};
        load_pattern(pc, 5'd16);
        for (int i = 0; i < GLOB_SLOTS; i++) send_item(16'h0000, i == GLOB_SLOTS - 1, 1'b0);
    endtask

    // empty names, case folding edges, literal star, zero-length pattern
    task automatic test_special_cases();
        logic [15:0] pc [GLOB_SLOTS];
        pc = '{default: 16'h0000};
        pc[0] = 16'h0041;
        pc[1] = wgm_pkg::GLOB_ANY_ONE;
        pc[2] = 16'h007A;
        pc[3] = wgm_pkg::GLOB_ANY_RUN;
        load_pattern(pc, 5'd4);
        // empty name against a pattern with literals
        send_item(16'hFFFF, 1'b0, 1'b1);
        // folded letters, literal star taken by '?'
        send_item(16'h0061, 1'b0, 1'b0);
        send_item(wgm_pkg::GLOB_ANY_RUN, 1'b0, 1'b0);
        send_item(16'h005A, 1'b1, 1'b0);
        // '@' sits just below the folding range
        send_item(16'h0040, 1'b0, 1'b0);
        send_item(16'h0078, 1'b0, 1'b0);
        send_item(16'h007A, 1'b1, 1'b0);
        // '[' sits just above it
        send_item(16'h0061, 1'b0, 1'b0);
        send_item(16'h0071, 1'b0, 1'b0);
        send_item(16'h005B, 1'b1, 1'b0);
        // trailing star swallows extreme characters
        send_item(16'h0041, 1'b0, 1'b0);
        send_item(16'h0071, 1'b0, 1'b0);
        send_item(16'h007A, 1'b0, 1'b0);
        send_item(16'hFFFF, 1'b0, 1'b0);
        send_item(16'h0000, 1'b1, 1'b0);
        // zero-length pattern
        load_pattern(pc, 5'd0);
        send_item(16'h0000, 1'b1, 1'b1);
        send_item(16'h0078, 1'b1, 1'b0);
        // all stars against an empty name
        pc[0] = wgm_pkg::GLOB_ANY_RUN;
        pc[1] = wgm_pkg::GLOB_ANY_RUN;
        load_pattern(pc, 5'd2);
        send_item(16'h1234, 1'b1, 1'b1);
        // star then '?' needs one character, a literal star will do
        pc[1] = wgm_pkg::GLOB_ANY_ONE;
        load_pattern(pc, 5'd2);
        send_item(16'h0000, 1'b0, 1'b1);
        send_item(wgm_pkg::GLOB_ANY_RUN, 1'b1, 1'b0);
    endtask

    task automatic test_random_names();
        int base;
        base = items_sent;
        while (items_sent - base < 1000) begin
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            random_pattern();
            repeat ($urandom_range(5, 20)) send_name(gen_name());
        end
    endtask

    // long sink hold while short names keep coming, so the input backs up
    task automatic test_output_stall();
        t_chars nm;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        random_pattern();
        stall_hold_request = 300;
        repeat (80) begin
            nm.delete();
            repeat ($urandom_range(1, 3)) nm = {nm, rand_char()};
            send_name(nm);
        end
    endtask

    // back-to-back traffic with no idling anywhere
    task automatic test_steady_stream();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        repeat (3) begin
            random_pattern();
            repeat (15) send_name(gen_name());
        end
    endtask

    // main sequence
    initial begin
        glob_pat = '{default: 16'h0000};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_pattern_registers();
        test_special_cases();
        test_random_names();
        test_output_stall();
        test_steady_stream();
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (match_expect_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", match_expect_q.size()));
        end
        if (mismatch_count == 0) begin
            $display("wildcard_glob_matcher_tb: clean");
        end else begin
            $display("wildcard_glob_matcher_tb: errors");
        end
        $finish;
    end

endmodule
